@@ rtl/iht_pkg.sv @@
// ----------------------------------------------------------------------------
// iht_pkg
// Shared types, codes and lookup builders for the interrupt handler table.
// ----------------------------------------------------------------------------
package iht_pkg;

	localparam int SLOT_COUNT_DEF    = 10;
	localparam int BANK_COUNT_DEF    = 3;
	localparam int BITS_PER_BANK_DEF = 32;

	localparam int CMD_W      = 2;
	localparam int IRQ_W      = 7;
	localparam int HID_W      = 8;
	localparam int WORD_W     = 32;
	localparam int STAT_W     = 2;
	localparam int SLOT_OUT_W = 4;
	localparam int PEND_BANKS = 3;
	localparam int IRQ_SPAN   = 1 << IRQ_W;
	// bank of the highest number fits here for bank widths of at least 8 bits
	localparam int BANK_IDX_W = 4;
	localparam int BIT_IDX_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_DISPATCH   = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_NOT_REG = 2'd2
	} status_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_CALL   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_COMMIT,
		S_STATUS,
		S_DONE
	} state_t;

	typedef logic [IRQ_SPAN-1:0][BANK_IDX_W-1:0] bank_lut_t;
	typedef logic [IRQ_SPAN-1:0][BIT_IDX_W-1:0]  bit_lut_t;

	// controller to datapath
	typedef struct packed {
		logic in_load;
		logic idx_inc;
		logic rd_issue;
		logic commit;
		logic out_call;
		logic out_status;
		logic out_done;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] in_cmd;
		logic [CMD_W-1:0] cur_cmd;
		logic             scan_end;
		logic             hit;
		logic             out_free;
	} dp_stat_t;

	// bank of every interrupt number, built by counting
	function automatic bank_lut_t make_bank_lut(input int bpb);
		bank_lut_t lut;
		int        b;
		int        r;
		b = 0;
		r = 0;
		for (int i = 0; i < IRQ_SPAN; i++) begin
			lut[i] = BANK_IDX_W'(b);
			r++;
			if (r == bpb) begin
				r = 0;
				b++;
			end
		end
		return lut;
	endfunction

	// bit position of every interrupt number inside its bank
	function automatic bit_lut_t make_bit_lut(input int bpb);
		bit_lut_t lut;
		int       r;
		r = 0;
		for (int i = 0; i < IRQ_SPAN; i++) begin
			lut[i] = BIT_IDX_W'(r);
			r++;
			if (r == bpb) begin
				r = 0;
			end
		end
		return lut;
	endfunction

endpackage

@@ rtl/iht_if.sv @@
// ----------------------------------------------------------------------------
// iht_if
// Request and response channels of the interrupt handler table.
// ----------------------------------------------------------------------------
interface iht_req_if;
	import iht_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IRQ_W-1:0]  irq_number;
	logic [HID_W-1:0]  handler_id;
	logic [WORD_W-1:0] pending_bank0;
	logic [WORD_W-1:0] pending_bank1;
	logic [WORD_W-1:0] pending_basic;

	modport source (
		output valid, cmd, irq_number, handler_id,
		output pending_bank0, pending_bank1, pending_basic,
		input  ready
	);

	modport sink (
		input  valid, cmd, irq_number, handler_id,
		input  pending_bank0, pending_bank1, pending_basic,
		output ready
	);
endinterface

interface iht_rsp_if;
	import iht_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [STAT_W-1:0]     status;
	logic [IRQ_W-1:0]      call_irq;
	logic [HID_W-1:0]      call_handler;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [WORD_W-1:0]     enable_word;
	logic                  last;

	modport source (
		output valid, kind, status, call_irq, call_handler,
		output slot_index, enable_word, last,
		input  ready
	);

	modport sink (
		input  valid, kind, status, call_irq, call_handler,
		input  slot_index, enable_word, last,
		output ready
	);
endinterface

@@ rtl/interrupt_handler_table_unit.sv @@
// ----------------------------------------------------------------------------
// interrupt_handler_table_unit
// Handler slot table with enable banks and pending-interrupt dispatch.
//
// One command is in flight at a time. The slot table sits in a memory with a
// single registered read port, so the controller examines each slot with a
// read followed by an evaluation. Register and unregister commit the first
// slot that fits, or report a status when none does; the status item then
// waits in the output register while the next command is accepted. Dispatch
// walks all slots, emitting at most one call per slot followed by the done
// item, and waits while the response side stalls. No clearing pass is needed
// after reset: slot valid bits clear at once.
// ----------------------------------------------------------------------------
module interrupt_handler_table_unit #(
	parameter int SLOT_COUNT    = iht_pkg::SLOT_COUNT_DEF,
	parameter int BANK_COUNT    = iht_pkg::BANK_COUNT_DEF,
	parameter int BITS_PER_BANK = iht_pkg::BITS_PER_BANK_DEF
) (
	input logic        clk,
	input logic        arst_n,
	iht_req_if.sink    req,
	iht_rsp_if.source  rsp
);
	import iht_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	iht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	iht_datapath #(
		.SLOT_COUNT    (SLOT_COUNT),
		.BANK_COUNT    (BANK_COUNT),
		.BITS_PER_BANK (BITS_PER_BANK)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_cmd           (req.cmd),
		.req_irq_number    (req.irq_number),
		.req_handler_id    (req.handler_id),
		.req_pending_bank0 (req.pending_bank0),
		.req_pending_bank1 (req.pending_bank1),
		.req_pending_basic (req.pending_basic),
		.cmd               (dp_cmd),
		.stat              (dp_stat),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_kind          (rsp.kind),
		.rsp_status        (rsp.status),
		.rsp_call_irq      (rsp.call_irq),
		.rsp_call_handler  (rsp.call_handler),
		.rsp_slot_index    (rsp.slot_index),
		.rsp_enable_word   (rsp.enable_word),
		.rsp_last          (rsp.last)
	);

endmodule

@@ rtl/iht_ctrl.sv @@
// ----------------------------------------------------------------------------
// iht_ctrl
// Sequencer: accepts a command, walks the slots, commits and emits results.
// ----------------------------------------------------------------------------
module iht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  iht_pkg::dp_stat_t stat,
	output iht_pkg::dp_cmd_t  cmd
);
	import iht_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.in_load = 1'b1;
					// drop unused codes without a result
					unique case (stat.in_cmd) inside
						CMD_REGISTER, CMD_UNREGISTER, CMD_DISPATCH: state_d = S_READ;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				if (stat.scan_end) begin
					state_d = (stat.cur_cmd == CMD_DISPATCH) ? S_DONE : S_STATUS;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = S_EVAL;
				end
			end
			S_EVAL: begin
				if (!stat.hit) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_READ;
				end else if (stat.cur_cmd != CMD_DISPATCH) begin
					state_d = S_COMMIT;
				end else if (stat.out_free) begin
					cmd.out_call = 1'b1;
					cmd.idx_inc  = 1'b1;
					state_d      = S_READ;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_STATUS;
			end
			S_STATUS: begin
				if (stat.out_free) begin
					cmd.out_status = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_done = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/iht_datapath.sv @@
// ----------------------------------------------------------------------------
// iht_datapath
// Slot store, enable banks, scan index, match logic and result register.
// ----------------------------------------------------------------------------
module iht_datapath #(
	parameter int SLOT_COUNT    = iht_pkg::SLOT_COUNT_DEF,
	parameter int BANK_COUNT    = iht_pkg::BANK_COUNT_DEF,
	parameter int BITS_PER_BANK = iht_pkg::BITS_PER_BANK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [iht_pkg::CMD_W-1:0]         req_cmd,
	input  logic [iht_pkg::IRQ_W-1:0]         req_irq_number,
	input  logic [iht_pkg::HID_W-1:0]         req_handler_id,
	input  logic [iht_pkg::WORD_W-1:0]        req_pending_bank0,
	input  logic [iht_pkg::WORD_W-1:0]        req_pending_bank1,
	input  logic [iht_pkg::WORD_W-1:0]        req_pending_basic,
	input  iht_pkg::dp_cmd_t                  cmd,
	output iht_pkg::dp_stat_t                 stat,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              rsp_kind,
	output logic [iht_pkg::STAT_W-1:0]        rsp_status,
	output logic [iht_pkg::IRQ_W-1:0]         rsp_call_irq,
	output logic [iht_pkg::HID_W-1:0]         rsp_call_handler,
	output logic [iht_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
	output logic [iht_pkg::WORD_W-1:0]        rsp_enable_word,
	output logic                              rsp_last
);
	import iht_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDX_W  = $clog2(SLOT_COUNT + 1);
	localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int BPB    = BITS_PER_BANK;

	localparam bank_lut_t BANK_LUT = make_bank_lut(BITS_PER_BANK);
	localparam bit_lut_t  BIT_LUT  = make_bit_lut(BITS_PER_BANK);

	// captured command
	logic [CMD_W-1:0]  cmd_q;
	logic [IRQ_W-1:0]  irq_q;
	logic [HID_W-1:0]  hid_q;
	logic [WORD_W-1:0] pend_q [PEND_BANKS];

	logic [IDX_W-1:0]      idx_q;
	logic                  found_q;
	logic [SLOT_COUNT-1:0] slot_valid_q;

	logic [IRQ_W-1:0] slot_irq_mem [SLOT_COUNT];
	logic [HID_W-1:0] slot_hid_mem [SLOT_COUNT];
	logic [IRQ_W-1:0] rd_irq_s1;
	logic [HID_W-1:0] rd_hid_s1;
	logic             rd_vld_s1;

	logic [BPB-1:0] enable_q [BANK_COUNT];

	logic [SLOT_W-1:0]     slot_addr;
	logic                  is_disp;
	logic [IRQ_W-1:0]      lk_irq;
	logic [BANK_IDX_W-1:0] lk_bank;
	logic [BIT_IDX_W-1:0]  lk_bit;
	logic                  lk_bank_ok;
	logic [BPB-1:0]        lk_enable;
	logic [BPB-1:0]        lk_mask;
	logic                  pend_hit;
	logic                  hit;
	logic                  out_free;

	assign slot_addr = idx_q[SLOT_W-1:0];
	assign is_disp   = (cmd_q == CMD_DISPATCH);

	// one bank lookup: the slot being dispatched, else the command's number
	assign lk_irq     = is_disp ? rd_irq_s1 : irq_q;
	assign lk_bank    = BANK_LUT[lk_irq];
	assign lk_bit     = BIT_LUT[lk_irq];
	assign lk_bank_ok = (lk_bank < BANK_IDX_W'(BANK_COUNT));
	assign lk_enable  = lk_bank_ok ? enable_q[lk_bank[BANK_W-1:0]] : '0;
	assign lk_mask    = {{(BPB-1){1'b0}}, 1'b1} << lk_bit;

	// only three pending words arrive; further banks never pend
	assign pend_hit = lk_bank_ok && (lk_bank < BANK_IDX_W'(PEND_BANKS))
		&& pend_q[lk_bank[1:0]][lk_bit];

	always_comb begin
		case (cmd_q)
			CMD_REGISTER:   hit = !rd_vld_s1;
			CMD_UNREGISTER: hit = rd_vld_s1 && (rd_irq_s1 == irq_q);
			CMD_DISPATCH:   hit = rd_vld_s1 && pend_hit;
			default:        hit = 1'b0;
		endcase
	end

	assign out_free = !rsp_valid || rsp_ready;

	assign stat.in_cmd   = req_cmd;
	assign stat.cur_cmd  = cmd_q;
	assign stat.scan_end = (idx_q == IDX_W'(SLOT_COUNT));
	assign stat.hit      = hit;
	assign stat.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			cmd_q     <= req_cmd;
			irq_q     <= req_irq_number;
			hid_q     <= req_handler_id;
			pend_q[0] <= req_pending_bank0;
			pend_q[1] <= req_pending_bank1;
			pend_q[2] <= req_pending_basic;
		end
	end

	// slot store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (cmd_q == CMD_REGISTER) begin
				slot_irq_mem[slot_addr] <= irq_q;
				slot_hid_mem[slot_addr] <= hid_q;
			end else begin
				slot_irq_mem[slot_addr] <= '0;
				slot_hid_mem[slot_addr] <= '0;
			end
		end
		if (cmd.rd_issue) begin
			rd_irq_s1 <= slot_irq_mem[slot_addr];
			rd_hid_s1 <= slot_hid_mem[slot_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			found_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			slot_valid_q <= '0;
			for (int b = 0; b < BANK_COUNT; b++) begin
				enable_q[b] <= '0;
			end
		end else begin
			if (cmd.in_load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.rd_issue) begin
				rd_vld_s1 <= slot_valid_q[slot_addr];
			end
			if (cmd.commit) begin
				found_q                 <= 1'b1;
				slot_valid_q[slot_addr] <= (cmd_q == CMD_REGISTER);
				if (lk_bank_ok) begin
					if (cmd_q == CMD_REGISTER) begin
						enable_q[lk_bank[BANK_W-1:0]] <= lk_enable | lk_mask;
					end else begin
						enable_q[lk_bank[BANK_W-1:0]] <= lk_enable & ~lk_mask;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.out_call || cmd.out_status || cmd.out_done) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_call) begin
			rsp_kind         <= KIND_CALL;
			rsp_status       <= STAT_OK;
			rsp_call_irq     <= rd_irq_s1;
			rsp_call_handler <= rd_hid_s1;
			rsp_slot_index   <= SLOT_OUT_W'(idx_q);
			rsp_enable_word  <= WORD_W'(lk_enable);
			rsp_last         <= 1'b0;
		end else if (cmd.out_status) begin
			rsp_kind         <= KIND_STATUS;
			if (found_q) begin
				rsp_status <= STAT_OK;
			end else if (cmd_q == CMD_REGISTER) begin
				rsp_status <= STAT_FULL;
			end else begin
				rsp_status <= STAT_NOT_REG;
			end
			rsp_call_irq     <= irq_q;
			rsp_call_handler <= '0;
			rsp_slot_index   <= found_q ? SLOT_OUT_W'(idx_q) : '0;
			rsp_enable_word  <= WORD_W'(lk_enable);
			rsp_last         <= 1'b1;
		end else if (cmd.out_done) begin
			rsp_kind         <= KIND_STATUS;
			rsp_status       <= STAT_OK;
			rsp_call_irq     <= '0;
			rsp_call_handler <= '0;
			rsp_slot_index   <= '0;
			rsp_enable_word  <= '0;
			rsp_last         <= 1'b1;
		end
	end

endmodule

@@ rtl/iht_checker.sv @@
// ----------------------------------------------------------------------------
// iht_checker
// Port-level checks of the interrupt handler table, bound to the top level.
// ----------------------------------------------------------------------------
module iht_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [iht_pkg::CMD_W-1:0]      req_cmd,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_kind,
	input logic [iht_pkg::STAT_W-1:0]     rsp_status,
	input logic [iht_pkg::IRQ_W-1:0]      rsp_call_irq,
	input logic [iht_pkg::HID_W-1:0]      rsp_call_handler,
	input logic [iht_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
	input logic [iht_pkg::WORD_W-1:0]     rsp_enable_word,
	input logic                           rsp_last
);
	import iht_pkg::*;

	// a stalled item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
			&& $stable(rsp_status) && $stable(rsp_call_irq)
			&& $stable(rsp_call_handler) && $stable(rsp_slot_index)
			&& $stable(rsp_enable_word) && $stable(rsp_last))
		else $error("response item changed while stalled");

	// after a real command the block is busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == CMD_REGISTER
			|| req_cmd == CMD_UNREGISTER || req_cmd == CMD_DISPATCH)
		|=> !req_ready)
		else $error("new command taken right after a real one");

	// a dispatch still in progress never takes the next command
	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("command accepted while dispatch results pending");

	a_call_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_CALL) |-> !rsp_last && (rsp_status == STAT_OK))
		else $error("handler call with last or error status");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STAT_OK)
		|-> rsp_last && (rsp_kind == KIND_STATUS) && (rsp_slot_index == '0))
		else $error("error status item malformed");

endmodule

bind interrupt_handler_table_unit iht_checker u_iht_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_cmd          (req.cmd),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_kind         (rsp.kind),
	.rsp_status       (rsp.status),
	.rsp_call_irq     (rsp.call_irq),
	.rsp_call_handler (rsp.call_handler),
	.rsp_slot_index   (rsp.slot_index),
	.rsp_enable_word  (rsp.enable_word),
	.rsp_last         (rsp.last)
);
